// File: rtl/mmc_pkg.sv
package mmc_pkg;

  // fixed field widths
  localparam int RAW_W = 16;
  localparam int CAL_W = 24;
  localparam int SCL_W = 16;
  localparam int TGT_W = 16;
  localparam int INV_W = 24;
  localparam int CFG_W = 24;
  localparam int IDX_W = 1;

  // tracked axes and sample counter width
  localparam int AXES       = 3;
  localparam int COUNT_BITS = 16;

  localparam int AXIS_W = (AXES > 1) ? $clog2(AXES) : 1;
  localparam int CMP_W  = (COUNT_BITS > TGT_W) ? COUNT_BITS : TGT_W;

  // scale divider widths
  localparam int RNG_W  = RAW_W;
  localparam int DEN_W  = RNG_W + $clog2(AXES + 1);
  localparam int SUM_W  = DEN_W;
  localparam int DIV_W  = DEN_W + 1;
  localparam int NUM_W  = SUM_W + 16;
  localparam int STEP_W = $clog2(SCL_W);

  // shared multiplier and rounding
  localparam int MA_W   = 32;
  localparam int MB_W   = INV_W;
  localparam int PROD_W = MA_W + MB_W;
  localparam int RND_SH = 30;
  localparam int Q_W    = PROD_W + 1 - RND_SH;

  // register indexes
  localparam logic [IDX_W-1:0] REG_TARGET = 1'b0;
  localparam logic [IDX_W-1:0] REG_INV    = 1'b1;

  // register reset values
  localparam logic [TGT_W-1:0] TARGET_RST = 16'd512;
  localparam logic [INV_W-1:0] INV_RST    = 24'd65536;

  // built-in calibration, offsets Q11.4, scales Q2.14
  localparam logic signed [RAW_W-1:0] DFLT_OFFSET [0:2] = '{16'sd77, -16'sd55, 16'sd118};
  localparam logic [SCL_W-1:0]        DFLT_SCALE  [0:2] = '{16'd15353, 16'd15633, 16'd18516};

  // controller to datapath commands
  typedef struct packed {
    logic              take;
    logic              dflt;
    logic              clr;
    logic              upd;
    logic              sum;
    logic              dprep;
    logic              dstep;
    logic              dstore;
    logic              mul1;
    logic              mul2;
    logic              rnd;
    logic              emit;
    logic              emit_cal;
    logic [AXIS_W-1:0] axis;
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic count_hit;
    logic div_sat;
    logic out_free;
  } status_t;

endpackage

// File: rtl/mmc_in_if.sv
interface mmc_in_if;
  logic                              valid;
  logic                              ready;
  logic                              cmd;
  logic signed [mmc_pkg::RAW_W-1:0]  mag_x;
  logic signed [mmc_pkg::RAW_W-1:0]  mag_y;
  logic signed [mmc_pkg::RAW_W-1:0]  mag_z;

  modport source (output valid, cmd, mag_x, mag_y, mag_z, input ready);
  modport sink   (input valid, cmd, mag_x, mag_y, mag_z, output ready);
endinterface

// File: rtl/mmc_out_if.sv
interface mmc_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [mmc_pkg::CAL_W-1:0]  cal_x;
  logic signed [mmc_pkg::CAL_W-1:0]  cal_y;
  logic signed [mmc_pkg::CAL_W-1:0]  cal_z;
  logic                              is_calibrated;

  modport source (output valid, cal_x, cal_y, cal_z, is_calibrated, input ready);
  modport sink   (input valid, cal_x, cal_y, cal_z, is_calibrated, output ready);
endinterface

// File: rtl/mmc_ctrl.sv
module mmc_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic             in_cmd,
  output logic             in_ready,
  input  mmc_pkg::status_t st,
  output mmc_pkg::cmd_t    cmd
);

  // sequencer states
  localparam logic [3:0] S_WAIT   = 4'd0;
  localparam logic [3:0] S_UPD    = 4'd1;
  localparam logic [3:0] S_CHECK  = 4'd2;
  localparam logic [3:0] S_SUM    = 4'd3;
  localparam logic [3:0] S_DPREP  = 4'd4;
  localparam logic [3:0] S_DCHK   = 4'd5;
  localparam logic [3:0] S_DSTEP  = 4'd6;
  localparam logic [3:0] S_DSTORE = 4'd7;
  localparam logic [3:0] S_MUL1   = 4'd8;
  localparam logic [3:0] S_MUL2   = 4'd9;
  localparam logic [3:0] S_RND    = 4'd10;
  localparam logic [3:0] S_EMIT   = 4'd11;

  // calibration phases
  localparam logic [2:0] PH_IDLE    = 3'd0;
  localparam logic [2:0] PH_START   = 3'd1;
  localparam logic [2:0] PH_COLLECT = 3'd2;
  localparam logic [2:0] PH_COMPUTE = 3'd3;
  localparam logic [2:0] PH_DONE    = 3'd4;

  localparam logic [mmc_pkg::AXIS_W-1:0] AXIS_LAST = mmc_pkg::AXIS_W'(mmc_pkg::AXES - 1);
  localparam logic [mmc_pkg::STEP_W-1:0] STEP_LAST = mmc_pkg::STEP_W'(mmc_pkg::SCL_W - 1);

  logic [3:0]                  state, state_next;
  logic [2:0]                  phase, phase_next;
  logic [mmc_pkg::AXIS_W-1:0]  axis, axis_next;
  logic [mmc_pkg::STEP_W-1:0]  step, step_next;
  logic                        em_cal, em_cal_next;
  logic                        axis_last;

  assign axis_last = (axis == AXIS_LAST);

  // next state and command decode
  always_comb begin
    state_next  = state;
    phase_next  = phase;
    axis_next   = axis;
    step_next   = step;
    em_cal_next = em_cal;
    in_ready    = 1'b0;
    cmd         = '0;
    cmd.axis     = axis;
    cmd.emit_cal = em_cal;
    case (state)
      S_WAIT: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.take = 1'b1;
          if (in_cmd) begin
            phase_next = PH_START;
          end else begin
            case (phase)
              PH_IDLE: begin
                cmd.dflt    = 1'b1;
                phase_next  = PH_DONE;
                em_cal_next = 1'b0;
                state_next  = S_EMIT;
              end
              PH_START: begin
                cmd.clr     = 1'b1;
                phase_next  = PH_COLLECT;
                em_cal_next = 1'b0;
                state_next  = S_EMIT;
              end
              PH_COLLECT: begin
                em_cal_next = 1'b0;
                state_next  = S_UPD;
              end
              PH_COMPUTE: begin
                phase_next  = PH_DONE;
                em_cal_next = 1'b0;
                state_next  = S_SUM;
              end
              default: begin
                em_cal_next = 1'b1;
                axis_next   = '0;
                state_next  = S_MUL1;
              end
            endcase
          end
        end
      end
      S_UPD: begin
        cmd.upd    = 1'b1;
        state_next = S_CHECK;
      end
      S_CHECK: begin
        if (st.count_hit) begin
          phase_next = PH_COMPUTE;
        end
        state_next = S_EMIT;
      end
      S_SUM: begin
        cmd.sum    = 1'b1;
        axis_next  = '0;
        state_next = S_DPREP;
      end
      S_DPREP: begin
        cmd.dprep  = 1'b1;
        state_next = S_DCHK;
      end
      S_DCHK: begin
        if (st.div_sat) begin
          if (axis_last) begin
            state_next = S_EMIT;
          end else begin
            axis_next  = axis + 1'b1;
            state_next = S_DPREP;
          end
        end else begin
          step_next  = '0;
          state_next = S_DSTEP;
        end
      end
      S_DSTEP: begin
        cmd.dstep = 1'b1;
        step_next = step + 1'b1;
        if (step == STEP_LAST) begin
          state_next = S_DSTORE;
        end
      end
      S_DSTORE: begin
        cmd.dstore = 1'b1;
        if (axis_last) begin
          state_next = S_EMIT;
        end else begin
          axis_next  = axis + 1'b1;
          state_next = S_DPREP;
        end
      end
      S_MUL1: begin
        cmd.mul1   = 1'b1;
        state_next = S_MUL2;
      end
      S_MUL2: begin
        cmd.mul2   = 1'b1;
        state_next = S_RND;
      end
      S_RND: begin
        cmd.rnd = 1'b1;
        if (axis_last) begin
          state_next = S_EMIT;
        end else begin
          axis_next  = axis + 1'b1;
          state_next = S_MUL1;
        end
      end
      S_EMIT: begin
        if (st.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_WAIT;
        end
      end
      default: begin
        state_next = S_WAIT;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_WAIT;
      phase  <= PH_IDLE;
      axis   <= '0;
      step   <= '0;
      em_cal <= 1'b0;
    end else begin
      state  <= state_next;
      phase  <= phase_next;
      axis   <= axis_next;
      step   <= step_next;
      em_cal <= em_cal_next;
    end
  end

endmodule

// File: rtl/mmc_dp.sv
module mmc_dp (
  input  logic                              clk,
  input  logic                              rst,
  input  mmc_pkg::cmd_t                     cmd,
  output mmc_pkg::status_t                  st,
  input  logic                              cfg_we,
  input  logic [mmc_pkg::IDX_W-1:0]         cfg_idx,
  input  logic [mmc_pkg::CFG_W-1:0]         cfg_data,
  input  logic signed [mmc_pkg::RAW_W-1:0]  mag_x,
  input  logic signed [mmc_pkg::RAW_W-1:0]  mag_y,
  input  logic signed [mmc_pkg::RAW_W-1:0]  mag_z,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [mmc_pkg::CAL_W-1:0]  cal_x,
  output logic signed [mmc_pkg::CAL_W-1:0]  cal_y,
  output logic signed [mmc_pkg::CAL_W-1:0]  cal_z,
  output logic                              is_calibrated
);

  localparam int AX = mmc_pkg::AXES;

  // configuration
  logic [mmc_pkg::TGT_W-1:0] target;
  logic [mmc_pkg::INV_W-1:0] inv;

  // per-axis stores
  logic signed [mmc_pkg::RAW_W-1:0] raw   [0:AX-1];
  logic signed [mmc_pkg::RAW_W-1:0] mn    [0:AX-1];
  logic signed [mmc_pkg::RAW_W-1:0] mx    [0:AX-1];
  logic signed [mmc_pkg::RAW_W-1:0] off   [0:AX-1];
  logic [mmc_pkg::SCL_W-1:0]        scl   [0:AX-1];
  logic [mmc_pkg::RNG_W-1:0]        rng   [0:AX-1];
  logic signed [mmc_pkg::CAL_W-1:0] acc   [0:AX-1];
  logic [mmc_pkg::COUNT_BITS-1:0]   count;

  // divider state
  logic [mmc_pkg::SUM_W-1:0] sum;
  logic [mmc_pkg::DIV_W-1:0] dreg;
  logic [mmc_pkg::DIV_W-1:0] rem;
  logic [15:0]               nlo;
  logic [mmc_pkg::SCL_W-1:0] quo;
  logic                      div_sat;

  // multiplier state
  logic [mmc_pkg::PROD_W-1:0] prod;
  logic                       sgn;

  logic signed [mmc_pkg::RAW_W-1:0] in_raw [0:2];
  logic signed [mmc_pkg::CAL_W-1:0] ov     [0:2];

  assign in_raw[0] = mag_x;
  assign in_raw[1] = mag_y;
  assign in_raw[2] = mag_z;

  // range, midpoint and running sum of ranges
  logic [mmc_pkg::RNG_W-1:0]        rng_c [0:AX-1];
  logic signed [mmc_pkg::RAW_W-1:0] mid_c [0:AX-1];
  logic [mmc_pkg::SUM_W-1:0]        sum_c;

  always_comb begin
    logic signed [mmc_pkg::RAW_W:0] ds;
    logic signed [mmc_pkg::RAW_W:0] ms;
    sum_c = '0;
    for (int a = 0; a < AX; a++) begin
      ds = {mx[a][mmc_pkg::RAW_W-1], mx[a]} - {mn[a][mmc_pkg::RAW_W-1], mn[a]};
      ms = {mx[a][mmc_pkg::RAW_W-1], mx[a]} + {mn[a][mmc_pkg::RAW_W-1], mn[a]};
      rng_c[a] = (ds > 0) ? ds[mmc_pkg::RNG_W-1:0] : '0;
      mid_c[a] = ms[mmc_pkg::RAW_W:1];
      sum_c = sum_c + mmc_pkg::SUM_W'(rng_c[a]);
    end
  end

  // divider setup: numerator, divisor and saturation check
  logic [mmc_pkg::DEN_W-1:0]    den_c;
  logic [mmc_pkg::DIV_W-1:0]    dv_c;
  logic [mmc_pkg::NUM_W-1:0]    num_c;
  logic                         ovf_c;

  assign den_c = mmc_pkg::DEN_W'(rng[cmd.axis]) * mmc_pkg::DEN_W'(AX);
  assign dv_c  = {den_c, 1'b0};
  assign num_c = (mmc_pkg::NUM_W'(sum) << 15) + mmc_pkg::NUM_W'(den_c);
  assign ovf_c = ({1'b0, num_c} >= {dv_c, 16'd0});

  // one restoring step
  logic [mmc_pkg::DIV_W:0]   r2_c;
  logic                      ge_c;
  logic [mmc_pkg::DIV_W:0]   rs_c;

  assign r2_c = {rem, nlo[15]};
  assign ge_c = (r2_c >= {1'b0, dreg});
  assign rs_c = r2_c - {1'b0, dreg};

  // magnitude of raw minus offset
  logic signed [mmc_pkg::RAW_W:0] diff_c;
  logic [mmc_pkg::RAW_W:0]        neg_c;
  logic [mmc_pkg::RAW_W-1:0]      mag_c;

  assign diff_c = {raw[cmd.axis][mmc_pkg::RAW_W-1], raw[cmd.axis]}
                - {off[cmd.axis][mmc_pkg::RAW_W-1], off[cmd.axis]};
  assign neg_c  = -diff_c;
  assign mag_c  = diff_c[mmc_pkg::RAW_W] ? neg_c[mmc_pkg::RAW_W-1:0]
                                         : diff_c[mmc_pkg::RAW_W-1:0];

  // shared multiplier operands
  logic [mmc_pkg::MA_W-1:0] mul_a;
  logic [mmc_pkg::MB_W-1:0] mul_b;

  always_comb begin
    if (cmd.mul2) begin
      mul_a = prod[mmc_pkg::MA_W-1:0];
      mul_b = inv;
    end else begin
      mul_a = mmc_pkg::MA_W'(mag_c);
      mul_b = mmc_pkg::MB_W'(scl[cmd.axis]);
    end
  end

  // round half away from zero and saturate
  logic [mmc_pkg::PROD_W:0]    rsum_c;
  logic [mmc_pkg::Q_W-1:0]     q_c;
  logic [mmc_pkg::Q_W-1:0]     lim_c;
  logic [mmc_pkg::Q_W-1:0]     qs_c;
  logic [mmc_pkg::CAL_W-1:0]   res_c;

  assign rsum_c = {1'b0, prod} + ((mmc_pkg::PROD_W + 1)'(1) << (mmc_pkg::RND_SH - 1));
  assign q_c    = rsum_c[mmc_pkg::PROD_W:mmc_pkg::RND_SH];
  assign lim_c  = sgn ? (mmc_pkg::Q_W'(1) << (mmc_pkg::CAL_W - 1))
                      : ((mmc_pkg::Q_W'(1) << (mmc_pkg::CAL_W - 1)) - 1'b1);
  assign qs_c   = (q_c > lim_c) ? lim_c : q_c;
  assign res_c  = sgn ? -qs_c[mmc_pkg::CAL_W-1:0] : qs_c[mmc_pkg::CAL_W-1:0];

  // status
  assign st.count_hit = (mmc_pkg::CMP_W'(count) >= mmc_pkg::CMP_W'(target)) || (&count);
  assign st.div_sat   = div_sat;
  assign st.out_free  = !out_valid || out_ready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      target <= mmc_pkg::TARGET_RST;
      inv    <= mmc_pkg::INV_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        mmc_pkg::REG_TARGET: target <= cfg_data[mmc_pkg::TGT_W-1:0];
        mmc_pkg::REG_INV:    inv    <= cfg_data[mmc_pkg::INV_W-1:0];
        default: ;
      endcase
    end
  end

  // per-axis stores
  always_ff @(posedge clk) begin
    for (int a = 0; a < AX; a++) begin
      if (cmd.take) begin
        raw[a] <= in_raw[a];
      end
      if (cmd.clr) begin
        mn[a] <= {1'b0, {(mmc_pkg::RAW_W-1){1'b1}}};
        mx[a] <= {1'b1, {(mmc_pkg::RAW_W-1){1'b0}}};
      end else if (cmd.upd) begin
        if (raw[a] < mn[a]) mn[a] <= raw[a];
        if (raw[a] > mx[a]) mx[a] <= raw[a];
      end
      if (cmd.dflt) begin
        off[a] <= mmc_pkg::DFLT_OFFSET[a];
        scl[a] <= mmc_pkg::DFLT_SCALE[a];
      end else if (cmd.sum) begin
        off[a] <= mid_c[a];
      end
      if (cmd.sum) begin
        rng[a] <= rng_c[a];
      end
    end
    if (cmd.dprep && (den_c == '0 || ovf_c)) begin
      scl[cmd.axis] <= '1;
    end else if (cmd.dstore) begin
      scl[cmd.axis] <= quo;
    end
    if (cmd.rnd) begin
      acc[cmd.axis] <= res_c;
    end
  end

  // sample counter, saturating
  always_ff @(posedge clk) begin
    if (cmd.clr) begin
      count <= '0;
    end else if (cmd.upd && !(&count)) begin
      count <= count + 1'b1;
    end
  end

  // scale divider
  always_ff @(posedge clk) begin
    if (cmd.sum) begin
      sum <= sum_c;
    end
    if (cmd.dprep) begin
      div_sat <= (den_c == '0) || ovf_c;
      dreg    <= dv_c;
      rem     <= mmc_pkg::DIV_W'(num_c[mmc_pkg::NUM_W-1:16]);
      nlo     <= num_c[15:0];
      quo     <= '0;
    end else if (cmd.dstep) begin
      rem <= ge_c ? rs_c[mmc_pkg::DIV_W-1:0] : r2_c[mmc_pkg::DIV_W-1:0];
      nlo <= {nlo[14:0], 1'b0};
      quo <= {quo[mmc_pkg::SCL_W-2:0], ge_c};
    end
  end

  // shared multiplier
  always_ff @(posedge clk) begin
    if (cmd.mul1 || cmd.mul2) begin
      prod <= mmc_pkg::PROD_W'(mul_a) * mmc_pkg::PROD_W'(mul_b);
    end
    if (cmd.mul1) begin
      sgn <= diff_c[mmc_pkg::RAW_W];
    end
  end

  // output values, zero for untracked axes and for uncalibrated beats
  for (genvar g = 0; g < 3; g++) begin : g_ov
    if (g < AX) begin : g_on
      assign ov[g] = cmd.emit_cal ? acc[g] : '0;
    end else begin : g_off
      assign ov[g] = '0;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      cal_x         <= ov[0];
      cal_y         <= ov[1];
      cal_z         <= ov[2];
      is_calibrated <= cmd.emit_cal;
    end
  end

endmodule

// File: rtl/magnetometer_minmax_calibrator_unit.sv
// channel  dir  handshake      payload
// din      in   valid/ready    cmd, mag_x, mag_y, mag_z
// dout     out  valid/ready    cal_x, cal_y, cal_z, is_calibrated
// cfg      in   cfg_we         cfg_idx, cfg_data
//
// start command: no result
// calibrated sample: paced by the
// shared 32x24 multiplier taking two products and a rounding step per axis
// compute sample: paced by the 16-step restoring divider per axis
// a finished beat waits in the output register while the next beat is taken
// synchronous reset, no clearing pass
module magnetometer_minmax_calibrator_unit (
  input  logic                      clk,
  input  logic                      rst,
  mmc_in_if.sink                    din,
  mmc_out_if.source                 dout,
  input  logic                      cfg_we,
  input  logic [mmc_pkg::IDX_W-1:0] cfg_idx,
  input  logic [mmc_pkg::CFG_W-1:0] cfg_data
);

  mmc_pkg::cmd_t    cmd;
  mmc_pkg::status_t st;

  // sequencer
  mmc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (din.valid),
    .in_cmd   (din.cmd),
    .in_ready (din.ready),
    .st       (st),
    .cmd      (cmd)
  );

  // datapath
  mmc_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .st            (st),
    .cfg_we        (cfg_we),
    .cfg_idx       (cfg_idx),
    .cfg_data      (cfg_data),
    .mag_x         (din.mag_x),
    .mag_y         (din.mag_y),
    .mag_z         (din.mag_z),
    .out_valid     (dout.valid),
    .out_ready     (dout.ready),
    .cal_x         (dout.cal_x),
    .cal_y         (dout.cal_y),
    .cal_z         (dout.cal_z),
    .is_calibrated (dout.is_calibrated)
  );

  // uncalibrated beats carry zeros
  a_zero_uncal: assert property (@(posedge clk) disable iff (rst)
    (dout.valid && !dout.is_calibrated) |->
      (dout.cal_x == '0 && dout.cal_y == '0 && dout.cal_z == '0))
    else $error("uncalibrated beat with nonzero field");

  // a start command never produces a result
  a_start_silent: assert property (@(posedge clk) disable iff (rst)
    (din.valid && din.ready && din.cmd) |=> !$rose(dout.valid))
    else $error("start command produced a result");

  // the block is busy in the cycle after it takes a sample
  a_sample_busy: assert property (@(posedge clk) disable iff (rst)
    (din.valid && din.ready && !din.cmd) |=> !din.ready)
    else $error("sample accepted without work");

endmodule

// File: bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  localparam int RAW_W = mmc_pkg::RAW_W;
  localparam int CAL_W = mmc_pkg::CAL_W;

  // input command codes
  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_START  = 1'b1;

  // built-in calibration loaded by the first sample after reset
  localparam logic signed [RAW_W-1:0] BUILTIN_OFS [3] = '{16'sd77, -16'sd55, 16'sd118};
  localparam logic [15:0]             BUILTIN_SCL [3] = '{16'd15353, 16'd15633, 16'd18516};

  localparam int  TRACKED_AXES = 3;
  localparam int  SETTLE_CYCLES = 80;
  localparam int  CYCLE_LIMIT   = 4000000;
  localparam int  MAX_REPORTS   = 10;

  typedef enum logic [2:0] {ST_IDLE, ST_START, ST_COLLECT, ST_COMPUTE, ST_DONE} run_state_t;

  typedef struct packed {
    logic signed [CAL_W-1:0] cal_x;
    logic signed [CAL_W-1:0] cal_y;
    logic signed [CAL_W-1:0] cal_z;
    logic                    is_calibrated;
  } cal_beat_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [mmc_pkg::IDX_W-1:0] cfg_idx;
  logic [mmc_pkg::CFG_W-1:0] cfg_data;

  mmc_in_if  din_if ();
  mmc_out_if dout_if ();

  magnetometer_minmax_calibrator_unit uut (
    .clk      (clk),
    .rst      (rst),
    .din      (din_if),
    .dout     (dout_if),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data)
  );

  // calibrator model state
  run_state_t              run_st = ST_IDLE;
  logic signed [RAW_W-1:0] seen_min [3];
  logic signed [RAW_W-1:0] seen_max [3];
  logic signed [RAW_W-1:0] axis_ofs [3];
  logic [15:0]             axis_scl [3];
  logic [15:0]             sample_cnt = '0;
  logic [15:0]             target_reg = 16'd512;
  logic [23:0]             inv_reg    = 24'd65536;

  cal_beat_t pending_cal [$];
  cal_beat_t got_beat;
  cal_beat_t want_beat;
  int        mismatches = 0;
  int        items_sent = 0;
  int        send_idle  = 16;
  int        recv_idle  = 73;
  int        cycle_count;

  // shape of the field cloud for the current run
  int run_ctr [3];
  int run_spr [3];

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // output ready with random stalls
  initial begin
    dout_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      dout_if.ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  // watchdog
  initial begin
    for (cycle_count = 0; cycle_count < CYCLE_LIMIT; cycle_count++) @(posedge clk);
    $display("tb: failure");
    $finish;
  end

  // one calibrated axis: (raw - offset) * scale * inv, round half away, saturate
  function automatic logic signed [CAL_W-1:0] scale_axis(input logic signed [RAW_W-1:0] raw,
                                                        input int a);
    logic signed [17:0] diff;
    logic [16:0]        mag;
    logic               neg;
    logic [63:0]        prod;
    logic [63:0]        q;
    diff = 18'(raw) - 18'(axis_ofs[a]);
    neg  = (diff < 0);
    mag  = 17'(neg ? -diff : diff);
    prod = 64'(mag) * 64'(axis_scl[a]) * 64'(inv_reg);
    q    = (prod + (64'd1 << 29)) >> 30;
    if (neg) begin
      if (q > 64'd8388608) q = 64'd8388608;
      q = ~q + 64'd1;
    end else if (q > 64'd8388607) begin
      q = 64'd8388607;
    end
    return q[CAL_W-1:0];
  endfunction

  // offsets from the midpoint, scales from mean range over axis range
  function automatic void derive_calibration();
    logic signed [16:0] span;
    logic signed [16:0] pair;
    logic [63:0]        rng [3];
    logic [63:0]        total;
    logic [63:0]        den;
    logic [63:0]        s;
    total = '0;
    for (int a = 0; a < TRACKED_AXES; a++) begin
      span   = seen_max[a] - seen_min[a];
      rng[a] = (span > 0) ? 64'(span) : 64'd0;
      total += rng[a];
      pair   = seen_max[a] + seen_min[a];
      axis_ofs[a] = pair[16:1];
    end
    for (int a = 0; a < TRACKED_AXES; a++) begin
      den = TRACKED_AXES * rng[a];
      if (den == 0) begin
        s = 64'd65535;
      end else begin
        s = ((total << 15) + den) / (den << 1);
        if (s > 64'd65535) s = 64'd65535;
      end
      axis_scl[a] = s[15:0];
    end
  endfunction

  // advance the model by one accepted beat and queue its result; a start queues none
  function automatic void predict_item(input logic c, input logic signed [RAW_W-1:0] x, y, z);
    logic signed [RAW_W-1:0] raw [3];
    cal_beat_t beat;
    beat   = '0;
    raw[0] = x;
    raw[1] = y;
    raw[2] = z;
    if (c == CMD_START) begin
      run_st = ST_START;
      return;
    end
    case (run_st)
      ST_IDLE: begin
        for (int a = 0; a < 3; a++) begin
          axis_ofs[a] = BUILTIN_OFS[a];
          axis_scl[a] = BUILTIN_SCL[a];
        end
        run_st = ST_DONE;
      end
      ST_START: begin
        for (int a = 0; a < 3; a++) begin
          seen_min[a] = 16'sh7FFF;
          seen_max[a] = 16'sh8000;
        end
        sample_cnt = '0;
        run_st = ST_COLLECT;
      end
      ST_COLLECT: begin
        for (int a = 0; a < TRACKED_AXES; a++) begin
          if (raw[a] < seen_min[a]) seen_min[a] = raw[a];
          if (raw[a] > seen_max[a]) seen_max[a] = raw[a];
        end
        if (sample_cnt != 16'hFFFF) sample_cnt++;
        if (sample_cnt >= target_reg || sample_cnt == 16'hFFFF) run_st = ST_COMPUTE;
      end
      ST_COMPUTE: begin
        derive_calibration();
        run_st = ST_DONE;
      end
      default: begin
        beat.cal_x = scale_axis(raw[0], 0);
        beat.cal_y = scale_axis(raw[1], 1);
        beat.cal_z = scale_axis(raw[2], 2);
        beat.is_calibrated = 1'b1;
      end
    endcase
    pending_cal.push_back(beat);
  endfunction

  // result checker
  always @(posedge clk) begin
    if (!rst && dout_if.valid === 1'b1 && dout_if.ready === 1'b1) begin
      got_beat.cal_x = dout_if.cal_x;
      got_beat.cal_y = dout_if.cal_y;
      got_beat.cal_z = dout_if.cal_z;
      got_beat.is_calibrated = dout_if.is_calibrated;
      if (pending_cal.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected beat: x=%0d y=%0d z=%0d cal=%0b", got_beat.cal_x,
                   got_beat.cal_y, got_beat.cal_z, got_beat.is_calibrated);
      end else begin
        want_beat = pending_cal.pop_front();
        if (got_beat.cal_x !== want_beat.cal_x || got_beat.cal_y !== want_beat.cal_y ||
            got_beat.cal_z !== want_beat.cal_z ||
            got_beat.is_calibrated !== want_beat.is_calibrated) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("beat mismatch: expected x=%0d y=%0d z=%0d cal=%0b, got x=%0d y=%0d z=%0d cal=%0b",
                     want_beat.cal_x, want_beat.cal_y, want_beat.cal_z, want_beat.is_calibrated,
                     got_beat.cal_x, got_beat.cal_y, got_beat.cal_z, got_beat.is_calibrated);
        end
      end
    end
  end

  // drive one beat and wait for it to be taken
  task automatic send_item(input logic c, input logic signed [RAW_W-1:0] x, y, z);
    while ($urandom_range(99) < send_idle) begin
      din_if.valid <= 1'b0;
      @(posedge clk);
    end
    din_if.valid <= 1'b1;
    din_if.cmd   <= c;
    din_if.mag_x <= x;
    din_if.mag_y <= y;
    din_if.mag_z <= z;
    @(posedge clk);
    while (din_if.ready !== 1'b1) @(posedge clk);
    predict_item(c, x, y, z);
    items_sent++;
  endtask

  // hold off until every queued result has come back
  task automatic drain_results();
    din_if.valid <= 1'b0;
    @(posedge clk);
    while (pending_cal.size() != 0) @(posedge clk);
  endtask

  // drained and quiet long enough for a register write
  task automatic wait_idle();
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [mmc_pkg::IDX_W-1:0] idx,
                           input logic [mmc_pkg::CFG_W-1:0] data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we   <= 1'b0;
    @(posedge clk);
    if (idx == mmc_pkg::REG_TARGET) target_reg = data[15:0];
    else inv_reg = data[23:0];
  endtask

  function automatic logic signed [RAW_W-1:0] pick_axis(input int a);
    int v;
    if ($urandom_range(9) == 0) v = int'($urandom_range(65535)) - 32768;
    else v = run_ctr[a] + int'($urandom_range(2 * run_spr[a])) - run_spr[a];
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[RAW_W-1:0];
  endfunction

  // new center and spread per axis, zero and tiny ranges included
  task automatic shape_run();
    for (int a = 0; a < 3; a++) begin
      run_ctr[a] = int'($urandom_range(65535)) - 32768;
      case ($urandom_range(3))
        0: run_spr[a] = 0;
        1: run_spr[a] = $urandom_range(8, 1);
        2: run_spr[a] = $urandom_range(2000, 16);
        default: run_spr[a] = 32767;
      endcase
    end
  endtask

  task automatic send_shaped();
    send_item(CMD_SAMPLE, pick_axis(0), pick_axis(1), pick_axis(2));
  endtask

  task automatic send_start();
    send_item(CMD_START, pick_axis(0), pick_axis(1), pick_axis(2));
  endtask

  // new target and sensitivity between runs
  task automatic retune();
    logic [23:0] inv;
    case ($urandom_range(5))
      0: inv = 24'd0;
      1: inv = 24'hFFFFFF;
      2: inv = 24'd65536;
      3: inv = 24'($urandom_range(24'hFFFFFF));
      default: inv = 24'($urandom_range(1 << 18));
    endcase
    wait_idle();
    write_reg(mmc_pkg::REG_TARGET,
              ($urandom_range(3) == 0) ? 24'd1 : 24'($urandom_range(12, 1)));
    write_reg(mmc_pkg::REG_INV, inv);
  endtask

  // first sample after reset loads built-ins, then built-in correction
  task automatic test_power_up();
    send_item(CMD_SAMPLE, 16'sh7FFF, 16'sh8000, 16'sh0000);
    send_item(CMD_SAMPLE, 16'sh8000, 16'sh7FFF, -16'sd1);
    send_item(CMD_SAMPLE, 16'sh7FFF, 16'sh8000, 16'sh5A5A);
  endtask

  // start from done, start, collect and compute phases
  task automatic test_start_each_phase();
    send_item(CMD_START, 16'sh0000, 16'sh0000, 16'sh0000);
    send_item(CMD_START, -16'sd1, -16'sd1, -16'sd1);
    send_item(CMD_SAMPLE, 16'sh1234, -16'sd300, 16'sd42);
    send_item(CMD_SAMPLE, 16'sd100, 16'sd200, 16'sd300);
    send_item(CMD_START, 16'sd5, 16'sd6, 16'sd7);
    send_item(CMD_SAMPLE, 16'sd9, 16'sd9, 16'sd9);
    wait_idle();
    write_reg(mmc_pkg::REG_TARGET, 24'd1);
    // single collected beat ends the run, then start lands in compute
    send_item(CMD_SAMPLE, 16'sd640, -16'sd320, 16'sd17);
    send_item(CMD_START, 16'sd0, 16'sd0, 16'sd0);
    send_item(CMD_SAMPLE, 16'sd1, 16'sd2, 16'sd3);
    // one collected beat: zero range on every axis
    send_item(CMD_SAMPLE, 16'sd640, -16'sd320, 16'sd17);
    send_item(CMD_SAMPLE, 16'sd0, 16'sd0, 16'sd0);
    send_item(CMD_SAMPLE, 16'sd641, -16'sd321, 16'sh8000);
  endtask

  // full range on x, range of one on y, zero range on z
  task automatic test_range_extremes();
    wait_idle();
    write_reg(mmc_pkg::REG_TARGET, 24'd3);
    send_item(CMD_START, 16'sd0, 16'sd0, 16'sd0);
    send_item(CMD_SAMPLE, 16'sh7FFF, 16'sh7FFF, 16'sh8000);
    send_item(CMD_SAMPLE, 16'sh8000, 16'sd100, 16'sd5);
    send_item(CMD_SAMPLE, 16'sh7FFF, 16'sd101, 16'sd5);
    send_item(CMD_SAMPLE, 16'sd0, 16'sd100, 16'sd5);
    send_item(CMD_SAMPLE, 16'sd0, 16'sd0, 16'sd0);
    send_item(CMD_SAMPLE, 16'sh8000, 16'sh7FFF, 16'sh8000);
  endtask

  // largest and zero sensitivity, output saturation both ways
  task automatic test_inv_extremes();
    wait_idle();
    write_reg(mmc_pkg::REG_INV, 24'hFFFFFF);
    send_item(CMD_SAMPLE, 16'sh7FFF, 16'sh8000, 16'sd0);
    send_item(CMD_SAMPLE, 16'sh8000, 16'sh7FFF, 16'sd1);
    wait_idle();
    write_reg(mmc_pkg::REG_INV, 24'd0);
    send_item(CMD_SAMPLE, 16'sd12345, -16'sd12345, 16'sh7FFF);
    wait_idle();
    write_reg(mmc_pkg::REG_INV, 24'd65536);
  endtask

  // mostly whole runs with random clouds, some broken runs and noise
  task automatic test_random(input int s_pct, input int r_pct, input int budget);
    int first;
    int kind;
    send_idle = s_pct;
    recv_idle = r_pct;
    first = items_sent;
    retune();
    while (items_sent - first < budget) begin
      kind = $urandom_range(99);
      if (kind < 10) begin
        retune();
      end else if (kind < 16) begin
        drain_results();
      end else if (kind < 72) begin
        shape_run();
        send_start();
        repeat (int'(target_reg) + 2) send_shaped();
        repeat ($urandom_range(6, 1)) send_shaped();
      end else if (kind < 86) begin
        shape_run();
        send_start();
        repeat ($urandom_range(int'(target_reg) + 1)) send_shaped();
      end else begin
        shape_run();
        run_spr = '{32767, 32767, 32767};
        repeat ($urandom_range(4, 1)) begin
          if ($urandom_range(6) == 0) send_start();
          else send_shaped();
        end
      end
    end
  endtask

  // long collection at a high target, then a short run
  task automatic test_long_run();
    send_idle = 0;
    recv_idle = 0;
    wait_idle();
    write_reg(mmc_pkg::REG_TARGET, 24'd160);
    write_reg(mmc_pkg::REG_INV, 24'd70000);
    shape_run();
    send_start();
    repeat (160 + 2) send_shaped();
    repeat (6) send_shaped();
    wait_idle();
    write_reg(mmc_pkg::REG_TARGET, 24'd4);
    shape_run();
    send_start();
    repeat (12) send_shaped();
  endtask

  // reset, then the tests in turn
  initial begin
    rst           <= 1'b1;
    cfg_we        <= 1'b0;
    cfg_idx       <= mmc_pkg::REG_TARGET;
    cfg_data      <= '0;
    din_if.valid  <= 1'b0;
    din_if.cmd    <= CMD_SAMPLE;
    din_if.mag_x  <= '0;
    din_if.mag_y  <= '0;
    din_if.mag_z  <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_power_up();
    test_start_each_phase();
    test_range_extremes();
    test_inv_extremes();
    test_random(16, 73, 360);
    test_random(73, 16, 360);
    test_random(0, 0, 370);
    test_long_run();

    wait_idle();
    if (mismatches == 0 && pending_cal.size() == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule

// File: filelist.f
rtl/mmc_pkg.sv
rtl/mmc_in_if.sv
rtl/mmc_out_if.sv
rtl/mmc_ctrl.sv
rtl/mmc_dp.sv
rtl/magnetometer_minmax_calibrator_unit.sv
bench/tb_top.sv
